[sv/u8s_pkg.sv]
package u8s_pkg;

  // default depth of the input queue
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [7:0] BYTE_NUL  = 8'h00;
  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] BYTE_FF   = 8'h0C;
  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] REPL_B0   = 8'hEF;
  localparam logic [7:0] REPL_B1   = 8'hBF;
  localparam logic [7:0] REPL_B2   = 8'hBD;
  localparam logic [1:0] CONT_TAG  = 2'b10;

  typedef enum logic [3:0] {
    K_PLAIN,
    K_LF,
    K_CR,
    K_FF,
    K_NUL,
    K_BAD,
    K_LEAD2,
    K_LEAD3,
    K_LEAD4
  } kind_e;

  // classified input transfer
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    kind_e      kind;
  } item_t;

  // group of up to four output bytes, data[0] goes out first
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      len;
    logic            last;
  } bundle_t;

  function automatic kind_e classify(input logic [7:0] b);
    kind_e k;
    if (b == BYTE_CR) begin
      k = K_CR;
    end else if (b == BYTE_FF) begin
      k = K_FF;
    end else if (b == BYTE_LF) begin
      k = K_LF;
    end else if (b == BYTE_NUL) begin
      k = K_NUL;
    end else if (b[7] == 1'b0) begin
      k = K_PLAIN;
    end else if (b[7:5] == 3'b110) begin
      k = K_LEAD2;
    end else if (b[7:4] == 4'b1110) begin
      k = K_LEAD3;
    end else if (b[7:3] == 5'b11110) begin
      k = K_LEAD4;
    end else begin
      k = K_BAD;
    end
    return k;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == CONT_TAG;
  endfunction

endpackage

[sv/u8s_front.sv]
module u8s_front #(
  parameter int unsigned FifoDepth = u8s_pkg::FIFO_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     in_data_i,
  input  logic           in_last_i,
  output logic           item_valid_o,
  input  logic           item_ready_i,
  output u8s_pkg::item_t item_o
);

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  u8s_pkg::item_t mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;
  u8s_pkg::item_t  new_item;

  assign in_ready_o   = cnt_q != CntW'(FifoDepth);
  assign item_valid_o = cnt_q != '0;
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    new_item.data = in_data_i;
    new_item.last = in_last_i;
    new_item.kind = u8s_pkg::classify(in_data_i);
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    cnt_d = cnt_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

[sv/u8s_core.sv]
module u8s_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  input  u8s_pkg::item_t   item_i,
  output logic             bnd_valid_o,
  input  logic             bnd_ready_i,
  output u8s_pkg::bundle_t bnd_o
);

  logic [7:0] buf_q [4];
  logic [7:0] buf_d [4];
  logic [2:0] cnt_q, cnt_d, exp_q, exp_d;
  logic       crp_q, crp_d;
  logic [7:0] rpl_q [3];
  logic [7:0] rpl_d [3];
  logic [1:0] rpl_cnt_q, rpl_cnt_d;
  logic       term_q, term_d;

  logic           src_rpl, src_term, src_fifo, src_ok, go;
  logic [7:0]     b;
  u8s_pkg::kind_e kind;
  logic [7:0]     s [4];
  logic [2:0]     cnt_n;
  logic [1:0]     j;
  logic           found;
  logic [7:0]     tmp [6];
  logic [2:0]     pos;
  u8s_pkg::bundle_t bnd;

  always_comb begin
    src_rpl  = rpl_cnt_q != 2'd0;
    src_term = !src_rpl && term_q;
    src_fifo = !src_rpl && !term_q && item_valid_i;
    src_ok   = src_rpl || term_q || item_valid_i;
    b        = src_rpl ? rpl_q[0] : item_i.data;
    kind     = src_rpl ? u8s_pkg::classify(rpl_q[0]) : item_i.kind;

    buf_d     = buf_q;
    cnt_d     = cnt_q;
    exp_d     = exp_q;
    crp_d     = crp_q;
    term_d    = term_q || (src_fifo && item_i.last);
    bnd.data  = '0;
    bnd.len   = 3'd0;
    bnd.last  = 1'b0;

    // default replay pop: the rest slides to the front
    for (int k = 0; k < 6; k++) begin
      tmp[k] = 8'h00;
    end
    rpl_d[0] = rpl_q[1];
    rpl_d[1] = rpl_q[2];
    rpl_d[2] = 8'h00;
    rpl_cnt_d = src_rpl ? rpl_cnt_q - 2'd1 : rpl_cnt_q;

    // sequence with the current byte placed at the fill point
    for (int k = 0; k < 4; k++) begin
      s[k] = (cnt_q[1:0] == 2'(k)) ? b : buf_q[k];
    end
    cnt_n = cnt_q + 3'd1;
    j     = 2'd0;
    found = 1'b0;
    for (int k = 1; k < 4; k++) begin
      if (!found && 3'(k) < exp_q && !u8s_pkg::is_cont(s[k])) begin
        found = 1'b1;
        j     = 2'(k);
      end
    end
    pos = 3'd0;

    if (src_term) begin
      // end of stream: cut-off sequence becomes a replacement, then terminator
      term_d = 1'b0;
      cnt_d  = 3'd0;
      exp_d  = 3'd0;
      crp_d  = 1'b0;
      bnd.last = 1'b1;
      if (exp_q != 3'd0) begin
        bnd.data = {u8s_pkg::BYTE_NUL, u8s_pkg::REPL_B2, u8s_pkg::REPL_B1,
                    u8s_pkg::REPL_B0};
        bnd.len  = 3'd4;
      end else begin
        bnd.data[0] = u8s_pkg::BYTE_NUL;
        bnd.len     = 3'd1;
      end
    end else if (exp_q == 3'd0) begin
      crp_d = 1'b0;
      if (!(crp_q && kind == u8s_pkg::K_LF)) begin
        case (kind)
          u8s_pkg::K_CR: begin
            bnd.data[0] = u8s_pkg::BYTE_LF;
            bnd.len     = 3'd1;
            crp_d       = 1'b1;
          end
          u8s_pkg::K_FF: begin
            bnd.data[0] = u8s_pkg::BYTE_LF;
            bnd.len     = 3'd1;
          end
          u8s_pkg::K_NUL, u8s_pkg::K_BAD: begin
            bnd.data[2:0] = {u8s_pkg::REPL_B2, u8s_pkg::REPL_B1, u8s_pkg::REPL_B0};
            bnd.len       = 3'd3;
          end
          u8s_pkg::K_LEAD2: begin
            buf_d[0] = b;
            cnt_d    = 3'd1;
            exp_d    = 3'd2;
          end
          u8s_pkg::K_LEAD3: begin
            buf_d[0] = b;
            cnt_d    = 3'd1;
            exp_d    = 3'd3;
          end
          u8s_pkg::K_LEAD4: begin
            buf_d[0] = b;
            cnt_d    = 3'd1;
            exp_d    = 3'd4;
          end
          default: begin
            bnd.data[0] = b;
            bnd.len     = 3'd1;
          end
        endcase
      end
    end else if (cnt_n < exp_q) begin
      buf_d[cnt_q[1:0]] = b;
      cnt_d             = cnt_n;
    end else if (!found) begin
      // well-formed sequence goes out unchanged
      for (int k = 0; k < 4; k++) begin
        bnd.data[k] = s[k];
      end
      bnd.len = exp_q;
      cnt_d   = 3'd0;
      exp_d   = 3'd0;
    end else begin
      // broken sequence: replacement, then replay from the offending byte on
      bnd.data[2:0] = {u8s_pkg::REPL_B2, u8s_pkg::REPL_B1, u8s_pkg::REPL_B0};
      bnd.len       = 3'd3;
      cnt_d         = 3'd0;
      exp_d         = 3'd0;
      for (int k = 1; k < 4; k++) begin
        if (2'(k) >= j && 3'(k) < exp_q) begin
          tmp[pos] = s[k];
          pos      = pos + 3'd1;
        end
      end
      for (int k = 1; k < 3; k++) begin
        if (src_rpl && 2'(k) < rpl_cnt_q) begin
          tmp[pos] = rpl_q[k];
          pos      = pos + 3'd1;
        end
      end
      for (int k = 0; k < 3; k++) begin
        rpl_d[k] = tmp[k];
      end
      rpl_cnt_d = pos[1:0];
    end

    go           = src_ok && (bnd.len == 3'd0 || bnd_ready_i);
    item_ready_o = go && src_fifo;
    bnd_valid_o  = go && bnd.len != 3'd0;
    bnd_o        = bnd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= 3'd0;
      exp_q     <= 3'd0;
      crp_q     <= 1'b0;
      rpl_cnt_q <= 2'd0;
      term_q    <= 1'b0;
    end else if (go) begin
      cnt_q     <= cnt_d;
      exp_q     <= exp_d;
      crp_q     <= crp_d;
      rpl_cnt_q <= rpl_cnt_d;
      term_q    <= term_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      buf_q <= buf_d;
      rpl_q <= rpl_d;
    end
  end

`ifndef SYNTHESIS
  a_open_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_q == 3'd0) == (cnt_q == 3'd0))
    else $error("sequence length and fill disagree");

  a_seq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exp_q != 3'd0) |-> (cnt_q < exp_q && exp_q <= 3'd4 && exp_q != 3'd1))
    else $error("open sequence out of range");

  a_held_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (4'(cnt_q) + 4'(rpl_cnt_q)) <= 4'd3)
    else $error("held and replayed bytes exceed three");

  a_term_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && src_term) |=> (exp_q == 3'd0 && !crp_q && !term_q && rpl_cnt_q == 2'd0))
    else $error("state not cleared after terminator");
`endif

endmodule

[sv/u8s_emit.sv]
module u8s_emit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             bnd_valid_i,
  output logic             bnd_ready_o,
  input  u8s_pkg::bundle_t bnd_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_data_o,
  output logic             out_last_o
);

  logic [3:0][7:0] data_q, data_d;
  logic [2:0]      cnt_q, cnt_d;
  logic            last_q, last_d;
  logic            pop;

  assign out_valid_o = cnt_q != 3'd0;
  assign pop         = out_valid_o && out_ready_i;
  assign bnd_ready_o = cnt_q == 3'd0 || (cnt_q == 3'd1 && out_ready_i);
  assign out_data_o  = data_q[0];
  assign out_last_o  = last_q && cnt_q == 3'd1;

  always_comb begin
    data_d = data_q;
    cnt_d  = cnt_q;
    last_d = last_q;
    if (bnd_valid_i && bnd_ready_o) begin
      data_d = bnd_i.data;
      cnt_d  = bnd_i.len;
      last_d = bnd_i.last;
    end else if (pop) begin
      data_d = {8'h00, data_q[3:1]};
      cnt_d  = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 3'd0;
      last_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

[sv/utf8_input_sanitizer.sv]
// channel   dir  tdata             tlast          tuser
// s_axis    in   [7:0] in_byte     in_last        -
// m_axis    out  [7:0] out_byte    out_last       -
//
// an ascii byte is registered in the input queue and again in the output register on its way to the output
// a 2..4 byte sequence is held until complete, then leaves as a burst at one byte a cycle while the output is ready
// a broken sequence replays up to three held bytes, one byte per cycle through the core unless the output stalls it
// after the last input byte the core spends a separate step on the terminator
// reset clears all control state at once; no clearing pass
// input queue and output register stall independently of each other
module utf8_input_sanitizer #(
  parameter int unsigned FifoDepth = u8s_pkg::FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // out_last
);

  // front to core: classified input transfers
  logic             item_valid, item_ready;
  u8s_pkg::item_t   item;

  // core to emitter: groups of output bytes
  logic             bnd_valid, bnd_ready;
  u8s_pkg::bundle_t bnd;

  // input queue with byte classification on entry
  u8s_front #(
    .FifoDepth (FifoDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  // sequence tracking, cr folding, replay of broken sequences, terminator
  u8s_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .bnd_valid_o  (bnd_valid),
    .bnd_ready_i  (bnd_ready),
    .bnd_o        (bnd)
  );

  // output register, serializes each group one byte per transfer
  u8s_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bnd_valid_i (bnd_valid),
    .bnd_ready_o (bnd_ready),
    .bnd_i       (bnd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

[bench/utf8_input_sanitizer_test.sv]
`timescale 1ns / 100ps

module utf8_input_sanitizer_test;

  localparam int RANDOM_ITEMS = 450;
  localparam int QUIET_ITEMS  = 60;       // tail of the run without idling
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int SETTLE       = 32;       // cycles allowed for stray output at the end

  // one raw text byte waiting to be sent; hold makes the sender drain first
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       hold;
  } text_byte_t;

  // one cleaned byte as it should leave the block
  typedef struct packed {
    logic [7:0] data;
    logic       term;
  } clean_byte_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] in_byte
  logic       s_axis_tlast  = 1'b0;   // in_last
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic       m_axis_tlast;           // out_last

  text_byte_t  text_q[$];    // raw bytes not yet offered
  clean_byte_t clean_q[$];   // cleaned bytes still owed by the block

  // shadow of the sanitizer state
  logic [7:0] seq_held [4];
  logic [2:0] seq_have;
  logic [2:0] seq_need;
  logic       after_cr;

  int   items_total;
  int   fed_count    = 0;
  int   drained      = 0;
  int   mismatches   = 0;
  int   cycle_count  = 0;
  int   pause_left   = 0;
  int   stall_left   = 0;
  logic quiet_tail   = 1'b0;

  utf8_input_sanitizer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void owe_byte(input logic [7:0] d, input logic t = 1'b0);
    clean_q.push_back('{data: d, term: t});
  endfunction

  function automatic void owe_replacement();
    owe_byte(u8s_pkg::REPL_B0);
    owe_byte(u8s_pkg::REPL_B1);
    owe_byte(u8s_pkg::REPL_B2);
  endfunction

  // a byte seen outside any open sequence
  function automatic void start_char(input logic [7:0] b);
    if (after_cr) begin
      after_cr = 1'b0;
      // lf right after cr was already emitted by the cr
      if (b == u8s_pkg::BYTE_LF) return;
    end
    if (b == u8s_pkg::BYTE_CR) begin
      owe_byte(u8s_pkg::BYTE_LF);
      after_cr = 1'b1;
    end else if (b == u8s_pkg::BYTE_FF) begin
      owe_byte(u8s_pkg::BYTE_LF);
    end else if (b == u8s_pkg::BYTE_NUL) begin
      owe_replacement();
    end else if (b[7] == 1'b0) begin
      owe_byte(b);
    end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
      // lead byte opens a sequence of 2, 3 or 4 bytes
      seq_held[0] = b;
      seq_have    = 3'd1;
      seq_need    = (b[7:5] == 3'b110) ? 3'd2 : (b[7:4] == 4'b1110) ? 3'd3 : 3'd4;
    end else begin
      // stray continuation byte or 0xf8 and above
      owe_replacement();
    end
  endfunction

  // works out every cleaned byte that one accepted raw byte causes
  function automatic void sanitize_byte(input logic [7:0] b, input logic last);
    logic [7:0] pend[$];
    logic [7:0] cur;
    int         j;
    int         k;
    pend.push_back(b);
    while (pend.size() != 0) begin
      cur = pend.pop_front();
      if (seq_need == 3'd0) begin
        start_char(cur);
      end else begin
        seq_held[seq_have[1:0]] = cur;
        seq_have++;
        if (seq_have == seq_need) begin
          j = 1;
          while (j < int'(seq_need) && seq_held[j][7:6] == u8s_pkg::CONT_TAG) j++;
          if (j == int'(seq_need)) begin
            for (k = 0; k < int'(seq_need); k++) owe_byte(seq_held[k]);
          end else begin
            // broken sequence: replacement, then replay from the offending byte
            owe_replacement();
            for (k = int'(seq_have) - 1; k >= j; k--) pend.push_front(seq_held[k]);
          end
          seq_have = 3'd0;
          seq_need = 3'd0;
        end
      end
    end
    if (last) begin
      // a sequence cut off by the end of the text
      if (seq_need != 3'd0) owe_replacement();
      seq_have = 3'd0;
      seq_need = 3'd0;
      after_cr = 1'b0;
      owe_byte(u8s_pkg::BYTE_NUL, 1'b1);
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void add_byte(input logic [7:0] d, input logic l = 1'b0,
                                   input logic h = 1'b0);
    text_q.push_back('{data: d, last: l, hold: h});
  endfunction

  // lead byte of a len-byte character and count-1 of its followers;
  // followers are all continuation bytes when clean, a random mix otherwise
  function automatic void add_char(input int len, input int count, input logic clean);
    int i;
    case (len)
      2:       add_byte(8'($urandom_range(8'hC0, 8'hDF)));
      3:       add_byte(8'($urandom_range(8'hE0, 8'hEF)));
      default: add_byte(8'($urandom_range(8'hF0, 8'hF7)));
    endcase
    for (i = 1; i < count; i++) begin
      if (clean || $urandom_range(0, 2) != 0) add_byte(8'($urandom_range(8'h80, 8'hBF)));
      else add_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  initial begin
    text_byte_t tail;
    int         n_tok;
    int         t;
    int         pick;
    int         first;
    int         stream_no;

    // single-byte text
    add_byte(8'h41, 1'b1);
    // nul, cr lf, form feed, cr cr, stray continuation, 0xff, 0xf8, top ascii
    add_byte(u8s_pkg::BYTE_NUL);
    add_byte(u8s_pkg::BYTE_CR);
    add_byte(u8s_pkg::BYTE_LF);
    add_byte(u8s_pkg::BYTE_FF);
    add_byte(u8s_pkg::BYTE_CR);
    add_byte(u8s_pkg::BYTE_CR);
    add_byte(8'h80);
    add_byte(8'hFF);
    add_byte(8'hF8);
    add_byte(8'h7F, 1'b1);
    // well-formed 2 and 3 byte characters
    add_byte(8'hC3);
    add_byte(8'hA9);
    add_byte(8'hE2);
    add_byte(8'h82);
    add_byte(8'hAC, 1'b1);
    // 4 byte character broken by ascii in its last slot; sent after a full drain
    add_byte(8'hF0, 1'b0, 1'b1);
    add_byte(8'h9F);
    add_byte(8'h98);
    add_byte(8'h41, 1'b1);
    // broken by cr, the replayed cr swallows the following lf
    add_byte(8'hE2);
    add_byte(u8s_pkg::BYTE_CR);
    add_byte(u8s_pkg::BYTE_LF, 1'b1);
    // cut off by the end of the text
    add_byte(8'hF4);
    add_byte(8'h8F, 1'b1);

    stream_no = 0;
    while (text_q.size() < RANDOM_ITEMS) begin
      first = text_q.size();
      n_tok = $urandom_range(1, 16);
      for (t = 0; t < n_tok; t++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) add_byte(8'($urandom_range(8'h20, 8'h7E)));
        else if (pick < 40) add_byte(8'($urandom_range(0, 255)));
        else if (pick < 44) add_byte(u8s_pkg::BYTE_CR);
        else if (pick < 48) add_byte(u8s_pkg::BYTE_LF);
        else if (pick < 51) add_byte(u8s_pkg::BYTE_FF);
        else if (pick < 53) add_byte(u8s_pkg::BYTE_NUL);
        else if (pick < 85) begin
          pick = $urandom_range(2, 4);
          add_char(pick, pick, 1'b1);
        end else begin
          pick = $urandom_range(2, 4);
          add_char(pick, pick, 1'b0);
        end
      end
      // sometimes end the text inside a character
      if ($urandom_range(0, 5) == 0) begin
        pick = $urandom_range(2, 4);
        add_char(pick, $urandom_range(1, pick - 1), 1'b1);
      end
      tail = text_q[text_q.size() - 1];
      tail.last = 1'b1;
      text_q[text_q.size() - 1] = tail;
      if (stream_no % 8 == 3) begin
        tail = text_q[first];
        tail.hold = 1'b1;
        text_q[first] = tail;
      end
      stream_no++;
    end
    items_total = text_q.size();

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (fed_count != items_total) @(posedge clk_i);
    while (clean_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("utf8_input_sanitizer verification clean");
    end else begin
      $display("utf8_input_sanitizer verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin
    text_byte_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tlast  <= 1'b0;
      quiet_tail    <= 1'b0;
      seq_have       = 3'd0;
      seq_need       = 3'd0;
      after_cr       = 1'b0;
      pause_left     = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        sanitize_byte(s_axis_tdata, s_axis_tlast);
        fed_count++;
      end
      quiet_tail <= (fed_count + QUIET_ITEMS >= items_total);
      if (s_axis_tvalid && !s_axis_tready) begin
        // offered transfer stays on the bus until taken
      end else if (pause_left != 0) begin
        pause_left--;
        s_axis_tvalid <= 1'b0;
      end else if (text_q.size() == 0 || (text_q[0].hold && clean_q.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        pause_left     = $urandom_range(1, 11) - 1;
        s_axis_tvalid <= 1'b0;
      end else begin
        nxt            = text_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.data;
        s_axis_tlast  <= nxt.last;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i or negedge rst_ni) begin
    clean_byte_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left     = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (clean_q.size() == 0) begin
          if (mismatches < 10)
            $display("output transfer %0d: nothing expected, got %02h last %0b",
                     drained, m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          want = clean_q.pop_front();
          if (m_axis_tdata !== want.data || m_axis_tlast !== want.term) begin
            if (mismatches < 10)
              $display("output transfer %0d: expected %02h last %0b, got %02h last %0b",
                       drained, want.data, want.term, m_axis_tdata, m_axis_tlast);
            mismatches++;
          end
        end
        drained++;
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        stall_left     = $urandom_range(1, 11) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("utf8_input_sanitizer verification failed");
      $finish;
    end
  end

endmodule
